// ===== design/cffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous first-fit allocator package
// Shared widths, operation and status codes, and register indexes.
// ----------------------------------------------------------------------------
package cffa_pkg;

	// Pool geometry
	localparam int POOL_UNITS  = 1024;
	localparam int OWNER_WIDTH = 8;
	localparam int ADDR_W      = $clog2(POOL_UNITS);
	localparam int CNT_W       = $clog2(POOL_UNITS + 1);

	// Field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int AMOUNT_W = 11;
	localparam int LIMIT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int BASE_W   = 10;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ALLOC_USER = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC_RT   = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE       = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_HELD    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOROOM  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FREED   = 2'd3;

	// Configuration register indexes
	localparam logic REG_USER_LIMIT = 1'b0;
	localparam logic REG_RT_LIMIT   = 1'b1;

	// Register reset values
	localparam logic [LIMIT_W-1:0] USER_LIMIT_RST = 11'd1024;
	localparam logic [LIMIT_W-1:0] RT_LIMIT_RST   = 11'd64;

endpackage

// ===== design/contiguous_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Contiguous first-fit allocator unit
// Keeps a pool of owner-tagged units in a single-port-write memory and serves
// allocate and free commands with one shared scan/write sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------
//  command   start / busy       operation, owner, amount, start_unit
//  result    done (strobe)      status, base_unit
//  config    cfg_write          cfg_index, cfg_data
//
// An allocate scans one unit per cycle from unit 0 up to the region limit,
// then writes one unit per cycle over the granted run. A free writes zero
// over its run, clipped at the last unit of the pool.
// Zero-length and unknown commands answer in the next cycle with no busy time.
// After reset a clearing pass zeroes the pool; busy is high.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module contiguous_first_fit_allocator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cffa_pkg::OP_W-1:0]           operation,
	input  logic [cffa_pkg::OWNER_WIDTH-1:0]    owner,
	input  logic [cffa_pkg::AMOUNT_W-1:0]       amount,
	input  logic [cffa_pkg::ADDR_W-1:0]         start_unit,
	output logic                                done,
	output logic [cffa_pkg::STATUS_W-1:0]       status,
	output logic [cffa_pkg::BASE_W-1:0]         base_unit,
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [cffa_pkg::LIMIT_W-1:0]        cfg_data
);

	// Sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;

	localparam logic [cffa_pkg::ADDR_W-1:0] LAST_UNIT =
		cffa_pkg::ADDR_W'(cffa_pkg::POOL_UNITS - 1);
	localparam logic [cffa_pkg::LIMIT_W-1:0] POOL_LIMIT =
		cffa_pkg::LIMIT_W'(cffa_pkg::POOL_UNITS);

	logic [2:0]                          state_q;
	logic [cffa_pkg::LIMIT_W-1:0]        user_limit_q;
	logic [cffa_pkg::LIMIT_W-1:0]        rt_limit_q;

	// Owner memory
	logic [cffa_pkg::OWNER_WIDTH-1:0]    pool_mem [cffa_pkg::POOL_UNITS];
	logic                                mem_we;
	logic [cffa_pkg::ADDR_W-1:0]         mem_waddr;
	logic [cffa_pkg::OWNER_WIDTH-1:0]    mem_wdata;

	// Scan pipeline
	logic [cffa_pkg::LIMIT_W-1:0]        issue_q;
	logic                                rd_valid_s1;
	logic [cffa_pkg::ADDR_W-1:0]         rd_idx_s1;
	logic [cffa_pkg::OWNER_WIDTH-1:0]    rd_data_s1;
	logic [cffa_pkg::AMOUNT_W-1:0]       run_q;
	logic [cffa_pkg::ADDR_W-1:0]         run_base_q;

	// Per-command payload
	logic [cffa_pkg::OWNER_WIDTH-1:0]    owner_q;
	logic [cffa_pkg::AMOUNT_W-1:0]       amount_q;
	logic [cffa_pkg::LIMIT_W-1:0]        limit_q;

	// Write and clear walker
	logic [cffa_pkg::ADDR_W-1:0]         wr_addr_q;
	logic [cffa_pkg::AMOUNT_W-1:0]       wr_left_q;
	logic [cffa_pkg::OWNER_WIDTH-1:0]    wr_data_q;
	logic [cffa_pkg::STATUS_W-1:0]       pend_status_q;
	logic [cffa_pkg::BASE_W-1:0]         pend_base_q;

	// Result register
	logic                                done_q;
	logic [cffa_pkg::STATUS_W-1:0]       status_q;
	logic [cffa_pkg::BASE_W-1:0]         base_q;

	logic                                accept;
	logic [cffa_pkg::LIMIT_W-1:0]        limit_sel;
	logic [cffa_pkg::LIMIT_W-1:0]        limit_eff;
	logic                                tag_free;
	logic                                tag_mine;
	logic [cffa_pkg::AMOUNT_W-1:0]       run_next;
	logic [cffa_pkg::ADDR_W-1:0]         cur_base;
	logic                                scan_found;
	logic                                scan_held;
	logic                                scan_exhausted;
	logic                                wr_last;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign status    = status_q;
	assign base_unit = base_q;

	// Region limit for the incoming command, clipped to the pool size
	assign limit_sel = (operation == cffa_pkg::OP_ALLOC_RT) ? rt_limit_q : user_limit_q;
	assign limit_eff = (limit_sel > POOL_LIMIT) ? POOL_LIMIT : limit_sel;

	// Evaluation of the unit read in the previous cycle
	assign tag_free       = (rd_data_s1 == '0);
	assign tag_mine       = (rd_data_s1 == owner_q);
	assign run_next       = run_q + 1'b1;
	assign cur_base       = (run_q == '0) ? rd_idx_s1 : run_base_q;
	assign scan_found     = rd_valid_s1 && tag_free && (run_next == amount_q);
	assign scan_held      = rd_valid_s1 && !tag_free && tag_mine;
	assign scan_exhausted = !rd_valid_s1 && (issue_q >= limit_q);

	// The walker stops at the run's end or at the last unit of the pool
	assign wr_last = (wr_left_q == cffa_pkg::AMOUNT_W'(1)) || (wr_addr_q == LAST_UNIT);

	// Memory write port: the clearing pass writes zero, the walker its tag
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = wr_data_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			S_WRITE: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Owner memory with a registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= pool_mem[issue_q[cffa_pkg::ADDR_W-1:0]];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_limit_q <= cffa_pkg::USER_LIMIT_RST;
			rt_limit_q   <= cffa_pkg::RT_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				cffa_pkg::REG_USER_LIMIT: user_limit_q <= cfg_data;
				cffa_pkg::REG_RT_LIMIT:   rt_limit_q   <= cfg_data;
				default:                  user_limit_q <= user_limit_q;
			endcase
		end
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			run_q       <= '0;
			wr_addr_q   <= '0;
			wr_left_q   <= '0;
			done_q      <= 1'b0;
			status_q    <= cffa_pkg::ST_GRANTED;
			base_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					wr_addr_q <= wr_addr_q + 1'b1;
					if (wr_addr_q == LAST_UNIT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (operation)
							cffa_pkg::OP_ALLOC_USER, cffa_pkg::OP_ALLOC_RT: begin
								if (amount == '0) begin
									done_q   <= 1'b1;
									status_q <= cffa_pkg::ST_GRANTED;
									base_q   <= '0;
								end else if (limit_eff == '0) begin
									done_q   <= 1'b1;
									status_q <= cffa_pkg::ST_NOROOM;
									base_q   <= '0;
								end else begin
									state_q     <= S_SCAN;
									issue_q     <= '0;
									rd_valid_s1 <= 1'b0;
									run_q       <= '0;
								end
							end
							cffa_pkg::OP_FREE: begin
								if (amount == '0) begin
									done_q   <= 1'b1;
									status_q <= cffa_pkg::ST_FREED;
									base_q   <= '0;
								end else begin
									state_q   <= S_WRITE;
									wr_addr_q <= start_unit;
									wr_left_q <= amount;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= cffa_pkg::ST_NOROOM;
								base_q   <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Keep issuing reads until the region limit is reached
					rd_valid_s1 <= (issue_q < limit_q);
					if (issue_q < limit_q) begin
						issue_q <= issue_q + 1'b1;
					end
					if (scan_found) begin
						state_q   <= S_WRITE;
						wr_addr_q <= cur_base;
						wr_left_q <= amount_q;
					end else if (scan_held) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= cffa_pkg::ST_HELD;
						base_q   <= '0;
					end else if (scan_exhausted) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= cffa_pkg::ST_NOROOM;
						base_q   <= '0;
					end else if (rd_valid_s1) begin
						run_q <= tag_free ? run_next : '0;
					end
				end
				S_WRITE: begin
					if (wr_last) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= pend_status_q;
						base_q   <= pend_base_q;
					end else begin
						wr_addr_q <= wr_addr_q + 1'b1;
						wr_left_q <= wr_left_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the command in progress
	always_ff @(posedge clk) begin
		if (accept) begin
			owner_q       <= owner;
			amount_q      <= amount;
			limit_q       <= limit_eff;
			wr_data_q     <= '0;
			pend_status_q <= cffa_pkg::ST_FREED;
			pend_base_q   <= '0;
		end else if (state_q == S_SCAN) begin
			rd_idx_s1 <= issue_q[cffa_pkg::ADDR_W-1:0];
			if (rd_valid_s1 && tag_free) begin
				run_base_q <= cur_base;
			end
			if (scan_found) begin
				wr_data_q     <= owner_q;
				pend_status_q <= cffa_pkg::ST_GRANTED;
				pend_base_q   <= cur_base;
			end
		end
	end

endmodule

// ===== design/cffa_checker.sv =====
// ----------------------------------------------------------------------------
// Contiguous first-fit allocator port checker
// Watches the top level's ports and flags results that break its contract.
// ----------------------------------------------------------------------------
module cffa_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [cffa_pkg::OP_W-1:0]        operation,
	input  logic [cffa_pkg::AMOUNT_W-1:0]    amount,
	input  logic                             done,
	input  logic [cffa_pkg::STATUS_W-1:0]    status,
	input  logic [cffa_pkg::BASE_W-1:0]      base_unit
);

	// Only a granted transfer may carry a nonzero base
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != cffa_pkg::ST_GRANTED)) |-> (base_unit == '0))
		else $error("nonzero base on a result that was not granted");

	// A result is preceded by an accepted command or by work in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a command");

	// A zero-length allocate answers granted at base zero in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (amount == '0) &&
		 ((operation == cffa_pkg::OP_ALLOC_USER) || (operation == cffa_pkg::OP_ALLOC_RT)))
		|=> (done && (status == cffa_pkg::ST_GRANTED) && (base_unit == '0)))
		else $error("zero-length allocate not granted at once");

	// A free either starts its write pass or answers freed at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == cffa_pkg::OP_FREE))
		|=> (busy || (done && (status == cffa_pkg::ST_FREED))))
		else $error("free command neither busy nor answered");

endmodule

bind contiguous_first_fit_allocator_unit cffa_checker u_cffa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.amount    (amount),
	.done      (done),
	.status    (status),
	.base_unit (base_unit)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the contiguous first-fit allocator unit
// Drives allocate, free and reserved commands through the start/busy port,
// rewrites both region limits between phases, and checks every result
// transfer against a cycle-free copy of the owner-tagged pool kept here.
// ----------------------------------------------------------------------------
module tb;
	import cffa_pkg::*;

	// Operation code that the block has no use for
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	// Cycles without any transfer before the run is abandoned
	localparam int QUIET_LIMIT = 8000;
	// Settling time after the last result: one full scan and write pass
	localparam int DRAIN_CYCLES = 2100;
	localparam int RANDOM_PER_SETTING = 45;
	localparam int SETTINGS = 6;

	typedef struct packed {
		logic [OP_W-1:0]        op;
		logic [OWNER_WIDTH-1:0] owner;
		logic [AMOUNT_W-1:0]    amount;
		logic [ADDR_W-1:0]      unit;
	} command_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BASE_W-1:0]   base;
	} answer_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [OP_W-1:0]        operation = '0;
	logic [OWNER_WIDTH-1:0] owner = '0;
	logic [AMOUNT_W-1:0]    amount = '0;
	logic [ADDR_W-1:0]      start_unit = '0;
	logic                   done;
	logic [STATUS_W-1:0]    status;
	logic [BASE_W-1:0]      base_unit;
	logic                   cfg_write = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [LIMIT_W-1:0]     cfg_data = '0;

	contiguous_first_fit_allocator_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.owner      (owner),
		.amount     (amount),
		.start_unit (start_unit),
		.done       (done),
		.status     (status),
		.base_unit  (base_unit),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Commands waiting to be offered, and answers owed by the block in order
	command_t command_q[$];
	answer_t  answers_due[$];

	// Local copy of the pool and of the two region limits
	logic [OWNER_WIDTH-1:0] pool_tag [POOL_UNITS] = '{default: '0};
	logic [LIMIT_W-1:0]     user_limit = USER_LIMIT_RST;
	logic [LIMIT_W-1:0]     rt_limit = RT_LIMIT_RST;

	logic cmd_taken = 1'b0;
	logic steady = 1'b0;
	int   faults = 0;
	int   quiet_cycles = 0;
	int   commands_sent = 0;
	int   n_granted = 0;
	int   n_held = 0;
	int   n_noroom = 0;
	int   n_freed = 0;

	// Clock: 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Works out the answer to one accepted command and applies it to the pool.
	function automatic answer_t work_out_answer(command_t c);
		answer_t a;
		int      lim;
		int      run;
		int      first;
		int      i;
		bit      found;
		bit      held;
		a.status = ST_NOROOM;
		a.base = '0;
		run = 0;
		first = 0;
		found = 1'b0;
		held = 1'b0;
		case (c.op)
			OP_ALLOC_USER, OP_ALLOC_RT: begin
				if (c.amount == '0) begin
					a.status = ST_GRANTED;
				end else begin
					lim = (c.op == OP_ALLOC_USER) ? int'(user_limit) : int'(rt_limit);
					if (lim > POOL_UNITS)
						lim = POOL_UNITS;
					// First fit: a unit of the same owner ends the search at once
					for (i = 0; i < lim && !found && !held; i++) begin
						if (pool_tag[i] == '0) begin
							if (run == 0)
								first = i;
							run++;
							if (run == int'(c.amount))
								found = 1'b1;
						end else if (pool_tag[i] == c.owner) begin
							held = 1'b1;
						end else begin
							run = 0;
						end
					end
					if (held) begin
						a.status = ST_HELD;
					end else if (found) begin
						for (i = first; i < first + int'(c.amount) && i < POOL_UNITS; i++)
							pool_tag[i] = c.owner;
						a.status = ST_GRANTED;
						a.base = BASE_W'(first);
					end
				end
			end
			OP_FREE: begin
				// The cleared run stops at the end of the pool
				for (i = int'(c.unit); i < int'(c.unit) + int'(c.amount) && i < POOL_UNITS; i++)
					pool_tag[i] = '0;
				a.status = ST_FREED;
			end
			default: begin
				a.status = ST_NOROOM;
			end
		endcase
		return a;
	endfunction

	// Command driver: offers queued commands on the falling edge and holds
	// each one until its transfer has taken place.
	always @(negedge clk) begin
		command_t next_cmd;
		logic     go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			go = start && !cmd_taken;
			if (!go && command_q.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
				next_cmd = command_q.pop_front();
				operation <= next_cmd.op;
				owner <= next_cmd.owner;
				amount <= next_cmd.amount;
				start_unit <= next_cmd.unit;
				go = 1'b1;
			end
			start <= go;
		end
	end

	// Monitor: follows register writes, predicts each command transfer,
	// checks each result transfer and watches for a stalled block.
	always @(posedge clk) begin
		command_t seen;
		answer_t  due;
		cmd_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == REG_USER_LIMIT)
					user_limit = cfg_data;
				else
					rt_limit = cfg_data;
			end
			if (done) begin
				if (answers_due.size() == 0) begin
					if (faults < 10)
						$display("%0t: result status %0d base %0d with no command outstanding",
							$time, status, base_unit);
					faults++;
				end else begin
					due = answers_due.pop_front();
					case (due.status)
						ST_GRANTED: n_granted++;
						ST_HELD:    n_held++;
						ST_NOROOM:  n_noroom++;
						default:    n_freed++;
					endcase
					if (status !== due.status || base_unit !== due.base) begin
						if (faults < 10)
							$display("%0t: got status %0d base %0d, expected status %0d base %0d",
								$time, status, base_unit, due.status, due.base);
						faults++;
					end
				end
			end
			// Predict after checking, so a stray strobe cannot claim this command
			if (start && !busy) begin
				seen.op = operation;
				seen.owner = owner;
				seen.amount = amount;
				seen.unit = start_unit;
				answers_due.push_back(work_out_answer(seen));
				commands_sent++;
			end
			if ((start && !busy) || done || cfg_write)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL contiguous_first_fit_allocator_unit");
				$finish;
			end
		end
	end

	task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [OWNER_WIDTH-1:0] who,
		input logic [AMOUNT_W-1:0] len, input logic [ADDR_W-1:0] unit);
		command_t c;
		c.op = op;
		c.owner = who;
		c.amount = len;
		c.unit = unit;
		command_q.push_back(c);
	endtask

	// Random command: a handful of owners so that owners often meet their
	// own units, mostly short runs, and now and then a wide free.
	function automatic command_t random_command();
		command_t c;
		int       pick;
		pick = $urandom_range(99);
		c.unit = ADDR_W'($urandom_range(POOL_UNITS - 1));
		case ($urandom_range(9))
			0:       c.owner = '0;
			1:       c.owner = OWNER_WIDTH'($urandom_range(255));
			2:       c.owner = '1;
			default: c.owner = OWNER_WIDTH'($urandom_range(1, 12));
		endcase
		case ($urandom_range(19))
			0:       c.amount = '0;
			1:       c.amount = AMOUNT_W'($urandom_range(2047));
			2:       c.amount = AMOUNT_W'($urandom_range(64, 300));
			default: c.amount = AMOUNT_W'($urandom_range(1, 24));
		endcase
		if (pick < 40)
			c.op = OP_ALLOC_USER;
		else if (pick < 62)
			c.op = OP_ALLOC_RT;
		else if (pick < 95)
			c.op = OP_FREE;
		else
			c.op = OP_RESERVED;
		if (c.op == OP_FREE && $urandom_range(9) == 0) begin
			c.unit = ADDR_W'($urandom_range(63));
			c.amount = AMOUNT_W'(POOL_UNITS);
		end
		return c;
	endfunction

	// Waits until every command has been taken and answered and the block
	// has gone idle. It looks at the rising edge, where the driver's start
	// of the previous falling edge has settled.
	task automatic wait_drained();
		while (command_q.size() != 0 || start || answers_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Stimulus: directed commands at the reset limits, then random phases
	initial begin
		logic [LIMIT_W-1:0] user_setting [SETTINGS];
		logic [LIMIT_W-1:0] rt_setting [SETTINGS];
		int                 s;
		int                 k;
		user_setting = '{11'd1024, 11'd2047, 11'd0, 11'd300, 11'd1, 11'd1024};
		rt_setting = '{11'd64, 11'd2047, 11'd0, 11'd17, 11'd1024, 11'd1};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_cmd(OP_ALLOC_USER, 8'd1, 11'd0, 10'd1023);     // zero amount
		queue_cmd(OP_ALLOC_USER, 8'd1, 11'd1, 10'd0);
		queue_cmd(OP_ALLOC_USER, 8'd1, 11'd5, 10'd0);        // owner meets its own unit
		queue_cmd(OP_ALLOC_USER, 8'd255, 11'd10, 10'd1023);
		queue_cmd(OP_ALLOC_RT, 8'd2, 11'd64, 10'd0);         // beyond the real-time region
		queue_cmd(OP_ALLOC_RT, 8'd2, 11'd53, 10'd0);         // fills it up exactly
		queue_cmd(OP_ALLOC_USER, 8'd0, 11'd4, 10'd0);        // owner zero leaves units free
		queue_cmd(OP_ALLOC_USER, 8'd3, 11'd4, 10'd0);
		queue_cmd(OP_FREE, 8'd9, 11'd1, 10'd0);
		queue_cmd(OP_ALLOC_USER, 8'd7, 11'd2047, 10'd0);     // larger than the pool
		queue_cmd(OP_RESERVED, 8'd9, 11'd5, 10'd7);
		queue_cmd(OP_FREE, 8'd1, 11'd2047, 10'd1000);        // clipped at the pool end
		queue_cmd(OP_FREE, 8'd1, 11'd2047, 10'd0);
		queue_cmd(OP_ALLOC_USER, 8'd128, 11'd1024, 10'd0);   // whole pool
		queue_cmd(OP_ALLOC_RT, 8'd129, 11'd1, 10'd0);
		queue_cmd(OP_ALLOC_USER, 8'd128, 11'd1, 10'd0);
		queue_cmd(OP_FREE, 8'd5, 11'd1, 10'd1023);
		queue_cmd(OP_ALLOC_USER, 8'd64, 11'd1, 10'd0);       // last unit of the pool
		queue_cmd(OP_FREE, 8'd5, 11'd0, 10'd512);
		queue_cmd(OP_ALLOC_USER, 8'd200, 11'd1, 10'd0);      // pool full
		queue_cmd(OP_FREE, 8'd5, 11'd1024, 10'd0);

		for (s = 0; s < SETTINGS; s++) begin
			// Limits change only once the block has gone quiet
			if (s != 0) begin
				wait_drained();
				write_limit(REG_USER_LIMIT, user_setting[s]);
				write_limit(REG_RT_LIMIT, rt_setting[s]);
			end
			steady = (s == 3);
			for (k = 0; k < RANDOM_PER_SETTING; k++)
				command_q.push_back(random_command());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (answers_due.size() != 0) begin
			$display("%0d results never arrived", answers_due.size());
			faults++;
		end
		$display("%0d commands over %0d limit settings: %0d granted, %0d already held,",
			commands_sent, SETTINGS, n_granted, n_held);
		$display("%0d without room or unknown, %0d frees; %0d mismatches",
			n_noroom, n_freed, faults);
		if (faults == 0)
			$display("PASS contiguous_first_fit_allocator_unit");
		else
			$display("FAIL contiguous_first_fit_allocator_unit");
		$finish;
	end

endmodule
